@@ hdl/isqrt_pkg.sv @@
package isqrt_pkg;

	localparam int RADICAND_BITS = 32;
	localparam int ROOT_BITS     = (RADICAND_BITS + 1) / 2;
	localparam int PAD_BITS      = 2 * ROOT_BITS;
	localparam int REM_BITS      = ROOT_BITS + 1;

	typedef struct packed {
		logic                valid;
		logic [REM_BITS-1:0] rem;
		logic [ROOT_BITS-1:0] root;
		logic [PAD_BITS-1:0]  rad;
	} isqrt_lane_t;

endpackage

@@ hdl/isqrt_cell.sv @@
module isqrt_cell import isqrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  isqrt_lane_t lane_in,
	output isqrt_lane_t lane_out
);

	logic [REM_BITS+1:0] partial;
	logic [REM_BITS+1:0] trial;
	logic [REM_BITS+1:0] diff;
	logic                fits;
	logic                valid_q;
	logic [REM_BITS-1:0] rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [PAD_BITS-1:0]  rad_q;

	// bring down the next two radicand bits and try root bit one
	always_comb begin
		partial = {lane_in.rem, lane_in.rad[PAD_BITS-1 -: 2]};
		trial   = {1'b0, lane_in.root, 2'b01};
		diff    = partial - trial;
		fits    = (partial >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= lane_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= fits ? diff[REM_BITS-1:0] : partial[REM_BITS-1:0];
			root_q <= ROOT_BITS'({lane_in.root, fits});
			rad_q  <= lane_in.rad << 2;
		end
	end

	assign lane_out.valid = valid_q;
	assign lane_out.rem   = rem_q;
	assign lane_out.root  = root_q;
	assign lane_out.rad   = rad_q;

endmodule

@@ hdl/integer_square_root_floor_unit.sv @@
// Floor of the square root of a 32-bit unsigned radicand, 16-bit root. The root is
// resolved by a row of 16 restoring cells, one root bit per cell, most significant
// first; each transaction is registered once per cell on its way out. The row moves as
// one pipeline: a new radicand may be accepted in every cycle, and the whole row holds
// while a finished root waits at the output with ready low.
module integer_square_root_floor_unit import isqrt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [RADICAND_BITS-1:0] radicand,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ROOT_BITS-1:0]     root
);

	isqrt_lane_t stage_lane [0:ROOT_BITS];
	logic        advance;

	assign advance = !stage_lane[ROOT_BITS].valid || out_ready;
	assign in_ready = advance;

	always_comb begin
		stage_lane[0].valid = in_valid;
		stage_lane[0].rem   = '0;
		stage_lane[0].root  = '0;
		stage_lane[0].rad   = PAD_BITS'(radicand);
	end

	for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
		isqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (advance),
			.lane_in  (stage_lane[i]),
			.lane_out (stage_lane[i+1])
		);
	end

	assign out_valid = stage_lane[ROOT_BITS].valid;
	assign root      = stage_lane[ROOT_BITS].root;

	// final remainder never exceeds twice the root
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, stage_lane[ROOT_BITS].rem} <= {root, 1'b0}))
		else $error("remainder exceeds twice the root");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> stage_lane[1].valid)
		else $error("accepted transaction did not enter the first cell");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(stage_lane[ROOT_BITS/2].valid)
			&& $stable(stage_lane[ROOT_BITS/2].root))
		else $error("cell row moved during output stall");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import isqrt_pkg::*;

	typedef struct packed {
		logic [RADICAND_BITS-1:0] radicand;
		logic [ROOT_BITS-1:0]     root;
	} root_expect_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [RADICAND_BITS-1:0] radicand = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [ROOT_BITS-1:0]     root;

	logic [RADICAND_BITS-1:0] pending_radicands[$];
	root_expect_t             expected_roots[$];
	root_expect_t             oldest_root;
	int                       mismatch_count = 0;
	int                       send_gap = 0;
	int                       recv_gap = 0;
	int                       idle_pct = 25;
	bit                       quiet = 1'b0;

	integer_square_root_floor_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.radicand  (radicand),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.root      (root)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// restoring digit-by-digit square root, floor form
	function automatic logic [ROOT_BITS-1:0] floor_root_of(logic [RADICAND_BITS-1:0] value);
		logic [63:0] rem;
		logic [63:0] acc;
		logic [63:0] probe;
		logic [63:0] trial;
		rem = 64'(value);
		acc = '0;
		probe = 64'd1 << 62;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			trial = acc + probe;
			if (rem >= trial) begin
				rem = rem - trial;
				acc = (acc >> 1) + probe;
			end else begin
				acc = acc >> 1;
			end
			probe = probe >> 2;
		end
		return acc[ROOT_BITS-1:0];
	endfunction

	task automatic report_mismatch(string what, root_expect_t want, logic [ROOT_BITS-1:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t mismatch (%s): radicand %h expected root %h got %h",
				$time, what, want.radicand, want.root, got);
	endtask

	task automatic wait_drained();
		while (pending_radicands.size() != 0 || expected_roots.size() != 0)
			@(posedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			radicand <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_roots.push_back('{radicand, floor_root_of(radicand)});
				void'(pending_radicands.pop_front());
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_radicands.size() != 0 && !quiet &&
						$urandom_range(99, 0) < idle_pct) begin
					send_gap = $urandom_range(5, 0);
					in_valid <= 1'b0;
				end else if (pending_radicands.size() != 0) begin
					in_valid <= 1'b1;
					radicand <= pending_radicands[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_roots.size() == 0) begin
					report_mismatch("unexpected transaction", '0, root);
				end else begin
					oldest_root = expected_roots.pop_front();
					if (root !== oldest_root.root)
						report_mismatch("root", oldest_root, root);
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(99, 0) < idle_pct) begin
				recv_gap = $urandom_range(5, 0);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned k;
		logic [RADICAND_BITS-1:0] r;
		int phase_pct[4];
		phase_pct = '{25, 0, 60, 35};
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		pending_radicands = '{
			32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd9, 32'd15, 32'd16,
			32'd24, 32'd25, 32'd65535, 32'd65536, 32'h3fff_ffff, 32'h4000_0000,
			32'h8000_0000, 32'hfffe_0000, 32'hfffe_0001, 32'hfffe_0002,
			32'hffff_fffe, 32'hffff_ffff, 32'haaaa_aaaa, 32'h5555_5555
		};
		wait_drained();

		for (int p = 0; p < 5; p++) begin
			if (p < 4)
				idle_pct = phase_pct[p];
			else
				quiet = 1'b1;
			for (int i = 0; i < ((p < 4) ? 450 : 200); i++) begin
				k = $urandom_range(65535, 0);
				case ($urandom_range(4, 0))
					0: r = $urandom;
					1: r = k * k;
					2: r = k * k - 1;
					3: r = k * k + 2 * k;
					default: r = $urandom >> $urandom_range(31, 0);
				endcase
				pending_radicands.push_back(r);
			end
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && expected_roots.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
hdl/isqrt_pkg.sv
hdl/isqrt_cell.sv
hdl/integer_square_root_floor_unit.sv
sim/tb.sv
